// ===== design/nrms_pkg.sv =====
// Shared types and constants for the normalized RMS error block.
`default_nettype none
package nrms_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_OUT_W = 11;
    localparam int SUM_W       = 64;
    localparam int ROOT_W      = 32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] model_sample;
        logic signed [SAMPLE_W-1:0] measured_sample;
        logic                       last;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0]    rms_error;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   overflow;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_MEAN,
        S_MDIV,
        S_SQRT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== design/nrms_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
`default_nettype none
module nrms_div
    import nrms_pkg::*;
#(
    parameter int DIV_W = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(SUM_W);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [SUM_W-1:0] r_quot;
    logic [DIV_W:0]   shifted;
    logic             ge;
    logic [DIV_W:0]   diff;

    assign shifted = {r_rem, r_quot[SUM_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low bits suffice
            r_rem  <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quot <= {r_quot[SUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== design/normalized_rms_error.sv =====
// Normalized RMS error: stores sample pairs in a single-port RAM until the pair
// marked last, then walks the RAM: each model sample is divided by the running
// maximum (1.0 if it stayed zero) in a shared bit-serial divider, the measured
// sample is subtracted and the square is added into a saturating 64-bit sum.
// The sum is divided by the count in the same divider and a 32-step integer
// root gives the result. Pairs are accepted one per cycle, but only while idle,
// so a new trace cannot start until the result of the last one has gone to the
// output register. Pairs beyond MAX_SAMPLES are dropped and flagged.
`default_nettype none
module normalized_rms_error
    import nrms_pkg::*;
#(
    parameter int MAX_SAMPLES   = 1024,
    parameter int FRACTION_BITS = 12
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int DIV_W  = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int Q_W    = SAMPLE_W + FRACTION_BITS + 1;
    localparam int D_W    = Q_W + 1;
    localparam int SQ_W   = 2 * D_W;

    logic [2*SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [2*SAMPLE_W-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_idx;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_dropped;
    logic                       r_sat;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_meas;
    logic signed [D_W-1:0]      r_q;
    logic [D_W-1:0]             r_ad;
    logic [SQ_W-1:0]            r_sq;
    logic [SUM_W-1:0]           r_v;
    logic [SUM_W-1:0]           r_root;
    logic [SUM_W-1:0]           r_bit;
    logic                       r_out_valid;
    t_out_word                  r_out;

    logic                 in_acc;
    logic                 room;
    logic [CNT_W-1:0]     count_after;
    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic [DIV_W-1:0]     div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quot;
    logic                 out_free;

    logic signed [SAMPLE_W-1:0] rd_model;
    logic [MAG_W-1:0]           rd_mag;
    logic [DIV_W-1:0]           max_div;
    logic signed [D_W-1:0]      diff_s;
    logic [SUM_W:0]             acc_sum;
    logic [SUM_W-1:0]           trial;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

    assign in_acc      = i_in_valid && o_in_ready;
    assign room        = r_count < CNT_W'(MAX_SAMPLES);
    assign count_after = room ? r_count + 1'b1 : r_count;
    assign out_free    = !r_out_valid || i_out_ready;

    assign rd_model = r_rd_data[SAMPLE_W-1:0];
    assign rd_mag   = rd_model[SAMPLE_W-1] ? MAG_W'(-$signed({rd_model[SAMPLE_W-1], rd_model}))
                                           : MAG_W'({1'b0, rd_model});
    assign max_div  = (r_max != '0) ? DIV_W'($unsigned(r_max))
                                    : DIV_W'(1 << FRACTION_BITS);
    assign diff_s   = r_q - D_W'(r_meas);
    assign acc_sum  = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign trial    = r_root + r_bit;
    assign cnt_wide = (CNT_W + COUNT_OUT_W)'(r_count);

    nrms_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.last)
                    n_state = (count_after != '0) ? S_READ : S_MEAN;
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = S_DIFF;
            end
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = (r_idx + 1'b1 == r_count) ? S_MEAN : S_READ;
            S_MEAN: n_state = (r_count == '0) ? S_DONE : S_MDIV;
            S_MDIV: begin
                if (div_done) n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_bit == SUM_W'(1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready   = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_sum;
        div_divisor  = DIV_W'(r_count);
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_LOAD: begin
                div_start    = 1'b1;
                div_dividend = SUM_W'(rd_mag) << FRACTION_BITS;
                div_divisor  = max_div;
            end
            S_MEAN: div_start = (r_count != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // pair RAM
    always_ff @(posedge i_clk) begin
        if (in_acc && room)
            mem[r_count[ADDR_W-1:0]] <= {i_in_data.measured_sample, i_in_data.model_sample};
        if (r_state == S_READ)
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
    end

    // trace control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_dropped   <= 1'b0;
            r_sat       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (in_acc) begin
                        if (room) begin
                            r_count <= r_count + 1'b1;
                            if (i_in_data.model_sample > r_max)
                                r_max <= i_in_data.model_sample;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                S_ACC: begin
                    r_idx <= r_idx + 1'b1;
                    if (acc_sum[SUM_W]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= acc_sum[SUM_W-1:0];
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_count     <= '0;
                        r_max       <= '0;
                        r_sum       <= '0;
                        r_dropped   <= 1'b0;
                        r_sat       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_neg  <= rd_model[SAMPLE_W-1];
                r_meas <= r_rd_data[2*SAMPLE_W-1:SAMPLE_W];
            end
            S_DIV: begin
                if (div_done)
                    r_q <= r_neg ? -$signed(D_W'(div_quot[Q_W-1:0]))
                                 : $signed(D_W'(div_quot[Q_W-1:0]));
            end
            S_DIFF: r_ad <= diff_s[D_W-1] ? D_W'(-diff_s) : D_W'(diff_s);
            S_MUL:  r_sq <= r_ad * r_ad;
            S_MEAN: begin
                // empty trace guard: root of zero
                r_v    <= '0;
                r_root <= '0;
            end
            S_MDIV: begin
                if (div_done) begin
                    r_v    <= div_quot;
                    r_root <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                end
            end
            S_SQRT: begin
                if (r_v >= trial) begin
                    r_v    <= r_v - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_root[ROOT_W-1:SAMPLE_W] != '0) begin
                        r_out.rms_error <= '1;
                        r_out.overflow  <= 1'b1;
                    end else begin
                        r_out.rms_error <= r_root[SAMPLE_W-1:0];
                        r_out.overflow  <= r_dropped || r_sat;
                    end
                    r_out.sample_count <= cnt_wide[COUNT_OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("pair count beyond capacity");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside final state");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_no_write_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !in_acc)
        else $error("pair written during evaluation pass");

endmodule
`default_nettype wire
